[rtl/pba_pkg.sv]
// Shared types, codes and constants of the paged bump allocator.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    // Fixed widths of the datapath
    localparam int unsigned ADDR_BITS  = 32;
    localparam int unsigned SUM_BITS   = 36;
    localparam int unsigned ALU_BITS   = 36;
    localparam int unsigned ALIGN_BITS = 17;

    // Page start rounding
    localparam int unsigned          PAGE_ALIGN      = 8;
    localparam logic [ADDR_BITS-1:0] PAGE_ALIGN_MASK = ADDR_BITS'(PAGE_ALIGN - 1);

    // Operation codes
    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_ADD_PAGE = 3'd1;
    localparam logic [2:0] OP_FREE_ALL = 3'd2;
    localparam logic [2:0] OP_GC       = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_PAGES  = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_BAD_ALIGN = 3'd3;
    localparam logic [2:0] ST_OOM       = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // Configuration register indexes
    localparam logic REG_ARENA_BASE  = 1'b0;
    localparam logic REG_GROW_ENABLE = 1'b1;

    // Request transaction
    typedef struct packed {
        logic [2:0]            op;
        logic [31:0]           size;
        logic [ALIGN_BITS-1:0] alignment;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [2:0]          status;
        logic [31:0]         address;
        logic [SUM_BITS-1:0] total_bytes;
        logic [SUM_BITS-1:0] allocated_bytes;
        logic [SUM_BITS-1:0] free_bytes;
        logic [4:0]          pages_in_use;
        logic [3:0]          active_page;
    } t_out_item;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_A_CUR,
        S_A_NEED,
        S_A_FIT,
        S_A_ADDR,
        S_G_READ,
        S_P_ROUND,
        S_P_HDR,
        S_P_END,
        S_FREE,
        S_GC_CHK,
        S_GC_END,
        S_Q_LEN,
        S_Q_USED,
        S_Q_F1,
        S_Q_F2,
        S_Q_F3,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/pba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/paged_bump_allocator_top.sv]
// Paged bump allocator: page table, sequencer and shared adder.
//
//  Channel   Direction  Handshake             Payload
//  in        request    i_in_valid/o_in_ready  i_in_item  (t_in_item)
//  out       result     o_out_valid/i_out_ready o_out_item (t_out_item)
//  config    APB write  psel/penable/pwrite   paddr, pwdata, prdata
//
// One request at a time runs through a sequencer that drives one 36-bit adder.
// Reset clears the page count, current page, arena pointers and grow enable.
// Completion holds while the output register is full; a new request is taken
// while the previous result still waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module paged_bump_allocator_top
    import pba_pkg::*;
#(
    parameter int unsigned MAX_PAGES    = 16,
    parameter int unsigned HEADER_BYTES = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_PAGES + 1);
    localparam int unsigned GEO_W = 2 * ADDR_BITS;

    // Control state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_total, n_total;
    logic [IDX_W-1:0]     r_current, n_current;
    logic [ADDR_BITS-1:0] r_arena_base, n_arena_base;
    logic [ADDR_BITS-1:0] r_arena_end, n_arena_end;
    logic                 r_grow_en, n_grow_en;
    logic                 r_out_valid, n_out_valid;

    // Working registers
    logic [2:0]            r_op, n_op;
    logic [31:0]           r_size, n_size;
    logic [ALIGN_BITS-1:0] r_align, n_align;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [ADDR_BITS-1:0]  r_cur, n_cur;
    logic [ADDR_BITS:0]    r_need, n_need;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic [2:0]            r_status, n_status;
    logic [ADDR_BITS-1:0]  r_plen, n_plen;
    logic [ADDR_BITS-1:0]  r_start, n_start;
    logic                  r_grown, n_grown;
    logic [SUM_BITS-1:0]   r_tot, n_tot;
    logic [SUM_BITS-1:0]   r_usum, n_usum;
    logic [SUM_BITS-1:0]   r_tpre, n_tpre;
    logic [SUM_BITS-1:0]   r_upre, n_upre;
    logic [SUM_BITS-1:0]   r_fr, n_fr;
    t_out_item             r_out, n_out;

    // Page table memories
    logic                 geo_we;
    logic [GEO_W-1:0]     geo_wdata;
    logic [GEO_W-1:0]     geo_rdata;
    logic                 used_we;
    logic [IDX_W-1:0]     used_waddr;
    logic [ADDR_BITS-1:0] used_wdata;
    logic [ADDR_BITS-1:0] used_rdata;

    // Shared adder
    logic [ALU_BITS-1:0] alu_a, alu_b, alu_y;
    logic                alu_sub;

    // Derived conditions
    logic                  in_fire, cfg_write, out_free;
    logic [ADDR_BITS-1:0]  pv_base, pv_len, pv_used;
    logic [ALIGN_BITS-1:0] pad;
    logic [CNT_W-1:0]      idx_next, total_m1;
    logic                  more_pages, table_full, fit, align_bad, alloc_reject;
    logic                  gc_more, gc_go;
    logic [63:0]           total_wide, current_wide;

    assign in_fire   = i_in_valid && o_in_ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !r_out_valid || i_out_ready;

    // Page under test: from the table, or the page just appended
    assign pv_base = r_grown ? r_start : geo_rdata[GEO_W-1:ADDR_BITS];
    assign pv_len  = r_grown ? r_plen  : geo_rdata[ADDR_BITS-1:0];
    assign pv_used = r_grown ? '0      : used_rdata;

    // Padding up to the requested alignment
    assign pad = (~r_cur[ALIGN_BITS-1:0] + ALIGN_BITS'(1)) & (r_align - ALIGN_BITS'(1));

    assign idx_next     = CNT_W'(r_idx) + CNT_W'(1);
    assign total_m1     = r_total - CNT_W'(1);
    assign more_pages   = idx_next < r_total;
    assign table_full   = r_total >= CNT_W'(MAX_PAGES);
    assign fit          = alu_y <= ALU_BITS'(pv_len);
    assign align_bad    = (r_align == '0) || ((r_align & (r_align - ALIGN_BITS'(1))) != '0);
    assign alloc_reject = (r_total == '0) || (r_size == '0) || align_bad;
    assign gc_go        = (r_total != '0) && (CNT_W'(r_current) < r_total);
    assign gc_more      = (total_m1 != '0) && (CNT_W'(r_current) < total_m1);

    // Adder: a + b, or a - b
    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_BITS'(alu_sub);

    // Select adder operands per step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_A_CUR: begin
                alu_a = ALU_BITS'(pv_base);
                alu_b = ALU_BITS'(pv_used);
            end
            S_A_NEED: begin
                alu_a = ALU_BITS'(r_size);
                alu_b = ALU_BITS'(pad);
            end
            S_A_FIT: begin
                alu_a = ALU_BITS'(pv_used);
                alu_b = ALU_BITS'(r_need);
            end
            S_A_ADDR: begin
                alu_a = ALU_BITS'(r_cur);
                alu_b = ALU_BITS'(pad);
            end
            S_P_ROUND: begin
                alu_a = ALU_BITS'(r_arena_end);
                alu_b = ALU_BITS'(PAGE_ALIGN_MASK);
            end
            S_P_HDR: begin
                alu_a = ALU_BITS'(r_start);
                alu_b = ALU_BITS'(HEADER_BYTES);
            end
            S_P_END: begin
                alu_a = ALU_BITS'(r_start);
                alu_b = ALU_BITS'(r_plen);
            end
            S_Q_LEN: begin
                alu_a = r_tot;
                alu_b = ALU_BITS'(pv_len);
            end
            S_Q_USED: begin
                alu_a = r_usum;
                alu_b = ALU_BITS'(pv_used);
            end
            S_Q_F1: begin
                alu_a   = r_tot;
                alu_b   = r_tpre;
                alu_sub = 1'b1;
            end
            S_Q_F2: begin
                alu_a   = r_fr;
                alu_b   = r_usum;
                alu_sub = 1'b1;
            end
            S_Q_F3: begin
                alu_a = r_fr;
                alu_b = r_upre;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (r_op)
                    OP_ALLOC:    n_state = alloc_reject ? S_DONE : S_A_CUR;
                    OP_ADD_PAGE: n_state = table_full ? S_DONE : S_P_ROUND;
                    OP_FREE_ALL: n_state = (r_total == '0) ? S_DONE : S_FREE;
                    OP_GC:       n_state = gc_go ? S_GC_CHK : S_GC_END;
                    OP_QUERY:    n_state = (r_total == '0) ? S_DONE : S_Q_LEN;
                    default:     n_state = S_DONE;
                endcase
            end
            S_A_CUR:  n_state = S_A_NEED;
            S_A_NEED: n_state = S_A_FIT;
            S_A_FIT: begin
                if (fit) begin
                    n_state = S_A_ADDR;
                end else if (r_grown) begin
                    n_state = S_DONE;
                end else if (more_pages) begin
                    n_state = S_A_CUR;
                end else if (!r_grow_en || table_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_G_READ;
                end
            end
            S_A_ADDR:  n_state = S_DONE;
            S_G_READ:  n_state = S_P_ROUND;
            S_P_ROUND: n_state = S_P_HDR;
            S_P_HDR:   n_state = S_P_END;
            S_P_END:   n_state = (r_op == OP_ALLOC) ? S_A_CUR : S_DONE;
            S_FREE:    n_state = more_pages ? S_FREE : S_DONE;
            S_GC_CHK: begin
                if (used_rdata != '0 || !gc_more) n_state = S_GC_END;
            end
            S_GC_END:  n_state = S_DONE;
            S_Q_LEN:   n_state = S_Q_USED;
            S_Q_USED:  n_state = more_pages ? S_Q_LEN : S_Q_F1;
            S_Q_F1:    n_state = S_Q_F2;
            S_Q_F2:    n_state = S_Q_F3;
            S_Q_F3:    n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and table writes
    always_comb begin
        n_total      = r_total;
        n_current    = r_current;
        n_arena_base = r_arena_base;
        n_arena_end  = r_arena_end;
        n_grow_en    = r_grow_en;
        n_op         = r_op;
        n_size       = r_size;
        n_align      = r_align;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_need       = r_need;
        n_addr       = r_addr;
        n_status     = r_status;
        n_plen       = r_plen;
        n_start      = r_start;
        n_grown      = r_grown;
        n_tot        = r_tot;
        n_usum       = r_usum;
        n_tpre       = r_tpre;
        n_upre       = r_upre;
        n_fr         = r_fr;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        geo_we       = 1'b0;
        geo_wdata    = {r_start, r_plen};
        used_we      = 1'b0;
        used_waddr   = r_idx;
        used_wdata   = '0;

        // Configuration writes
        if (cfg_write) begin
            unique case (paddr[2])
                REG_ARENA_BASE: begin
                    n_arena_base = pwdata;
                    n_arena_end  = pwdata;
                end
                REG_GROW_ENABLE: n_grow_en = pwdata[0];
                default:         n_grow_en = r_grow_en;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = i_in_item.op;
                    n_size  = i_in_item.size;
                    n_align = i_in_item.alignment;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_addr   = '0;
                n_grown  = 1'b0;
                n_tot    = '0;
                n_usum   = '0;
                n_tpre   = '0;
                n_upre   = '0;
                n_fr     = '0;
                unique case (r_op)
                    OP_ALLOC: begin
                        n_idx = r_current;
                        if (r_total == '0) begin
                            n_status = ST_NO_PAGES;
                        end else if (r_size == '0) begin
                            n_status = ST_ZERO_SIZE;
                        end else if (align_bad) begin
                            n_status = ST_BAD_ALIGN;
                        end
                    end
                    OP_ADD_PAGE: begin
                        n_plen = r_size;
                        if (table_full) n_status = ST_FULL;
                    end
                    OP_FREE_ALL: begin
                        n_current = '0;
                        n_idx     = '0;
                    end
                    OP_GC: begin
                        n_idx = IDX_W'(total_m1);
                    end
                    OP_QUERY: begin
                        n_idx = '0;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_A_CUR: begin
                n_cur = alu_y[ADDR_BITS-1:0];
            end
            S_A_NEED: begin
                n_need = alu_y[ADDR_BITS:0];
            end
            S_A_FIT: begin
                if (fit) begin
                    used_we    = 1'b1;
                    used_wdata = alu_y[ADDR_BITS-1:0];
                    n_current  = r_idx;
                end else if (r_grown) begin
                    n_status = ST_OOM;
                end else if (more_pages) begin
                    n_idx = IDX_W'(idx_next);
                end else if (!r_grow_en || table_full) begin
                    n_status = ST_OOM;
                end else begin
                    n_idx = IDX_W'(total_m1);
                end
            end
            S_A_ADDR: begin
                n_addr = alu_y[ADDR_BITS-1:0];
            end
            S_G_READ: begin
                n_plen = geo_rdata[ADDR_BITS-1:0];
            end
            S_P_ROUND: begin
                n_start = alu_y[ADDR_BITS-1:0] & ~PAGE_ALIGN_MASK;
            end
            S_P_HDR: begin
                n_start = alu_y[ADDR_BITS-1:0];
            end
            S_P_END: begin
                // Place the page and bump the arena end
                geo_we      = 1'b1;
                used_we     = 1'b1;
                used_waddr  = IDX_W'(r_total);
                n_arena_end = alu_y[ADDR_BITS-1:0];
                n_total     = r_total + CNT_W'(1);
                if (r_op == OP_ALLOC) begin
                    n_idx     = IDX_W'(r_total);
                    n_current = IDX_W'(r_total);
                    n_grown   = 1'b1;
                end
            end
            S_FREE: begin
                used_we = 1'b1;
                if (more_pages) n_idx = IDX_W'(idx_next);
            end
            S_GC_CHK: begin
                // Drop an empty trailing page
                if (used_rdata == '0) begin
                    n_total = total_m1;
                    n_idx   = IDX_W'(total_m1 - CNT_W'(1));
                end
            end
            S_GC_END: begin
                n_current = (r_total != '0) ? IDX_W'(total_m1) : '0;
            end
            S_Q_LEN: begin
                if (r_idx == r_current) begin
                    n_tpre = r_tot;
                    n_upre = r_usum;
                end
                n_tot = alu_y;
            end
            S_Q_USED: begin
                n_usum = alu_y;
                if (more_pages) n_idx = IDX_W'(idx_next);
            end
            S_Q_F1, S_Q_F2, S_Q_F3: begin
                n_fr = alu_y;
            end
            S_DONE: begin
                // Hand the result to the output register
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = r_status;
                    n_out.address         = r_addr;
                    n_out.total_bytes     = (r_op == OP_QUERY) ? r_tot  : '0;
                    n_out.allocated_bytes = (r_op == OP_QUERY) ? r_usum : '0;
                    n_out.free_bytes      = (r_op == OP_QUERY) ? r_fr   : '0;
                    n_out.pages_in_use    = total_wide[4:0];
                    n_out.active_page     = current_wide[3:0];
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    assign total_wide   = 64'(r_total);
    assign current_wide = 64'(r_current);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_current    <= '0;
            r_arena_base <= '0;
            r_arena_end  <= '0;
            r_grow_en    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_current    <= n_current;
            r_arena_base <= n_arena_base;
            r_arena_end  <= n_arena_end;
            r_grow_en    <= n_grow_en;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_size   <= n_size;
        r_align  <= n_align;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_need   <= n_need;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_plen   <= n_plen;
        r_start  <= n_start;
        r_grown  <= n_grown;
        r_tot    <= n_tot;
        r_usum   <= n_usum;
        r_tpre   <= n_tpre;
        r_upre   <= n_upre;
        r_fr     <= n_fr;
        r_out    <= n_out;
    end

    // Page base and length
    pba_ram #(
        .WIDTH (GEO_W),
        .DEPTH (MAX_PAGES)
    ) u_geo_ram (
        .i_clk   (i_clk),
        .i_we    (geo_we),
        .i_waddr (IDX_W'(r_total)),
        .i_wdata (geo_wdata),
        .i_raddr (n_idx),
        .o_rdata (geo_rdata)
    );

    // Used bytes per page
    pba_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (MAX_PAGES)
    ) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (n_idx),
        .o_rdata (used_rdata)
    );

    // Ports
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_GROW_ENABLE) ? {31'd0, r_grow_en} : r_arena_base;

endmodule

`default_nettype wire

[dv/pba_result_checker.sv]
// Result checker for the paged bump allocator: tracks page table state and compares results.
`timescale 1ns / 1ps

module pba_result_checker
    import pba_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned GAP_BYTES   = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_item,
    // result channel
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_item,
    // configuration port
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [2:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    // status toward the testbench top
    output int unsigned      o_mismatch_count,
    output int unsigned      o_pending
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow page table
    logic [31:0] page_start [TABLE_DEPTH];
    logic [31:0] page_bytes [TABLE_DEPTH];
    logic [31:0] page_taken [TABLE_DEPTH];
    int unsigned page_count;
    int unsigned active_idx;
    logic [31:0] arena_top;
    logic        grow_on;

    // Results owed by the block, oldest first
    t_out_item expected_results [$];

    // Append a page at the rounded arena end plus the header gap
    function automatic bit push_page(input logic [31:0] len);
        logic [31:0] start;
        if (page_count >= TABLE_DEPTH) return 1'b0;
        start = ((arena_top + 32'(PAGE_ALIGN - 1)) & ~PAGE_ALIGN_MASK) + 32'(GAP_BYTES);
        page_start[page_count] = start;
        page_bytes[page_count] = len;
        page_taken[page_count] = '0;
        arena_top  = start + len;
        page_count = page_count + 1;
        return 1'b1;
    endfunction

    // Take an aligned block from one page if it fits
    function automatic bit carve(input int unsigned p, input logic [31:0] nbytes,
                                 input logic [31:0] align, output logic [31:0] addr);
        logic [31:0] cur;
        logic [31:0] pad;
        logic [31:0] room;
        addr = '0;
        if (p >= page_count) return 1'b0;
        cur  = page_start[p] + page_taken[p];
        pad  = (-cur) & (align - 32'd1);
        room = page_bytes[p] - page_taken[p];
        if (pad > room || nbytes > room - pad) return 1'b0;
        page_taken[p] = page_taken[p] + pad + nbytes;
        addr = cur + pad;
        return 1'b1;
    endfunction

    // Advance the shadow state by one request and return the result it owes
    function automatic t_out_item allocator_step(input t_in_item req);
        t_out_item           res;
        logic [31:0]         align_val;
        logic [31:0]         hit;
        logic [SUM_BITS-1:0] len_sum;
        logic [SUM_BITS-1:0] used_sum;
        logic [SUM_BITS-1:0] room_sum;
        int unsigned         i;
        bit                  placed;
        res       = '0;
        hit       = '0;
        len_sum   = '0;
        used_sum  = '0;
        room_sum  = '0;
        align_val = 32'(req.alignment);
        case (req.op)
            OP_ALLOC: begin
                if (page_count == 0) begin
                    res.status = ST_NO_PAGES;
                end else if (req.size == 0) begin
                    res.status = ST_ZERO_SIZE;
                end else if (align_val == 0 || (align_val & (align_val - 32'd1)) != 0) begin
                    res.status = ST_BAD_ALIGN;
                end else begin
                    // try the current page, then every later one
                    placed = 1'b0;
                    for (i = active_idx; i < page_count && !placed; i++) begin
                        if (carve(i, req.size, align_val, hit)) begin
                            placed     = 1'b1;
                            active_idx = i;
                        end
                    end
                    // grow by a copy of the last page length
                    if (!placed && grow_on && push_page(page_bytes[page_count - 1])) begin
                        active_idx = page_count - 1;
                        placed     = carve(active_idx, req.size, align_val, hit);
                    end
                    res.status  = placed ? ST_OK : ST_OOM;
                    res.address = placed ? hit : '0;
                end
            end
            OP_ADD_PAGE: begin
                if (!push_page(req.size)) res.status = ST_FULL;
            end
            OP_FREE_ALL: begin
                for (i = 0; i < page_count; i++) page_taken[i] = '0;
                active_idx = 0;
            end
            OP_GC: begin
                // pop empty pages from the tail, never below the current page
                while (page_count > 0 && page_count - 1 >= active_idx &&
                       page_taken[page_count - 1] == 0)
                    page_count = page_count - 1;
                active_idx = (page_count > 0) ? page_count - 1 : 0;
            end
            OP_QUERY: begin
                for (i = 0; i < page_count; i++) begin
                    len_sum  = len_sum + SUM_BITS'(page_bytes[i]);
                    used_sum = used_sum + SUM_BITS'(page_taken[i]);
                    if (i >= active_idx)
                        room_sum = room_sum + SUM_BITS'(page_bytes[i] - page_taken[i]);
                end
                res.total_bytes     = len_sum;
                res.allocated_bytes = used_sum;
                res.free_bytes      = room_sum;
            end
            default: ;
        endcase
        res.pages_in_use = 5'(page_count);
        res.active_page  = 4'(active_idx);
        return res;
    endfunction

    function automatic bit same_result(input t_out_item want, input t_out_item got);
        return want.status === got.status && want.address === got.address &&
               want.total_bytes === got.total_bytes &&
               want.allocated_bytes === got.allocated_bytes &&
               want.free_bytes === got.free_bytes &&
               want.pages_in_use === got.pages_in_use &&
               want.active_page === got.active_page;
    endfunction

    // Count a failure; show the first few in full
    task automatic report_failure(input string what, input bit has_want,
                                  input t_out_item want, input t_out_item got);
        if (o_mismatch_count < REPORT_LIMIT) begin
            if (has_want)
                $display("%s: want st=%0d addr=%h tot=%h used=%h free=%h pages=%0d cur=%0d",
                         what, want.status, want.address, want.total_bytes,
                         want.allocated_bytes, want.free_bytes, want.pages_in_use,
                         want.active_page);
            $display("%s:  got st=%0d addr=%h tot=%h used=%h free=%h pages=%0d cur=%0d",
                     what, got.status, got.address, got.total_bytes,
                     got.allocated_bytes, got.free_bytes, got.pages_in_use,
                     got.active_page);
        end
        o_mismatch_count++;
    endtask

    // Watch all three ports on the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int p = 0; p < TABLE_DEPTH; p++) begin
                page_start[p] = '0;
                page_bytes[p] = '0;
                page_taken[p] = '0;
            end
            page_count = 0;
            active_idx = 0;
            arena_top  = '0;
            grow_on    = 1'b0;
            expected_results.delete();
            o_mismatch_count = 0;
        end else begin
            // compare the result transaction with the oldest one owed
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_failure("unexpected result", 1'b0, '0, i_out_item);
                end else begin
                    want = expected_results.pop_front();
                    if (!same_result(want, i_out_item))
                        report_failure("result mismatch", 1'b1, want, i_out_item);
                end
            end
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_ARENA_BASE)
                    arena_top = i_pwdata;
                else if (i_paddr[2] == REG_GROW_ENABLE)
                    grow_on = i_pwdata[0];
            end
            // predict the request transaction
            if (i_in_valid && i_in_ready)
                expected_results.push_back(allocator_step(i_in_item));
        end
        o_pending = expected_results.size();
    end

endmodule

[dv/paged_bump_allocator_top_tb.sv]
// Testbench top for the paged bump allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module paged_bump_allocator_top_tb;
    import pba_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1350;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned IDLE_PERCENT = 37;
    localparam int unsigned STEADY_FROM  = 600;
    localparam int unsigned STEADY_TO    = 800;

    // Op codes the block ignores
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatch_total;
    int unsigned results_owed;
    int unsigned counted_ops;
    int unsigned cycle_count;
    bit          steady;

    paged_bump_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pba_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in_item        (i_in_item),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_item       (o_out_item),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatch_count (mismatch_total),
        .o_pending        (results_owed)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at random, except during the steady stretch
    initial i_out_ready = 1'b0;
    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
    end

    // Give up after a generous number of cycles
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("paged_bump_allocator_top regression: fail");
        $finish;
    end

    // Write one register through a setup and an access cycle
    task automatic write_reg(input logic reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_owed != 0) @(negedge i_clk);
    endtask

    // Offer one request transaction, idling first at random
    task automatic send_request(input logic [2:0] op, input logic [31:0] size,
                                input logic [ALIGN_BITS-1:0] align);
        t_in_item item;
        item.op        = op;
        item.size      = size;
        item.alignment = align;
        steady = counted_ops >= STEADY_FROM && counted_ops < STEADY_TO;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        counted_ops++;
    endtask

    function automatic logic [ALIGN_BITS-1:0] pick_alignment();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return ALIGN_BITS'(1) << $urandom_range(6, 0);
        if (r < 90) return ALIGN_BITS'(1) << $urandom_range(16, 7);
        if (r < 94) return '0;
        return ALIGN_BITS'($urandom);
    endfunction

    function automatic logic [31:0] pick_alloc_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(96, 1);
        if (r < 88) return $urandom_range(1024, 97);
        if (r < 93) return '0;
        if (r < 97) return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(3, 0);
    endfunction

    function automatic logic [31:0] pick_page_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(512, 16);
        if (r < 88) return $urandom_range(15, 0);
        if (r < 95) return $urandom_range(8192, 513);
        if (r < 98) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_arena_base();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return '0;
        if (r < 40) return 32'hFFFF_FFFF;
        if (r < 60) return 32'hFFFF_FF00 + $urandom_range(255, 0);
        return $urandom;
    endfunction

    // Stimulus
    initial begin
        int unsigned kind;
        int unsigned burst;
        int unsigned r;
        logic [2:0]  op;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        counted_ops = 0;
        steady     = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: checks in order, ignored ops, edge sizes, sums, cleanup
        write_reg(REG_ARENA_BASE, 32'h0000_1003);
        write_reg(REG_GROW_ENABLE, 32'd0);
        send_request(OP_ALLOC, 32'd16, ALIGN_BITS'(8));
        for (op = OP_RESERVED_FIRST; op != OP_ALLOC; op++)
            send_request(op, 32'hFFFF_FFFF, '1);
        send_request(OP_ADD_PAGE, 32'd256, '0);
        send_request(OP_ALLOC, 32'd0, ALIGN_BITS'(8));
        send_request(OP_ALLOC, 32'd8, ALIGN_BITS'(0));
        send_request(OP_ALLOC, 32'd8, ALIGN_BITS'(3));
        send_request(OP_ALLOC, 32'd8, '1);
        send_request(OP_ALLOC, 32'd1, ALIGN_BITS'(17'h1_0000));
        send_request(OP_ALLOC, 32'd1, ALIGN_BITS'(1));
        send_request(OP_ALLOC, 32'd32, ALIGN_BITS'(16));
        send_request(OP_ALLOC, 32'hFFFF_FFFF, ALIGN_BITS'(1));
        send_request(OP_ADD_PAGE, 32'd0, '0);
        send_request(OP_ADD_PAGE, 32'hFFFF_FFFF, '0);
        send_request(OP_QUERY, '0, '0);
        send_request(OP_FREE_ALL, '0, '0);
        send_request(OP_GC, '0, '0);
        send_request(OP_QUERY, '0, '0);
        send_request(OP_GC, '0, '0);
        send_request(OP_FREE_ALL, '0, '0);

        // Directed: wrapped arena end, growth that fits and growth that falls short
        settle();
        write_reg(REG_ARENA_BASE, 32'hFFFF_FFFF);
        write_reg(REG_GROW_ENABLE, 32'd1);
        send_request(OP_ADD_PAGE, 32'd64, '0);
        send_request(OP_ALLOC, 32'd48, ALIGN_BITS'(1));
        send_request(OP_ALLOC, 32'd48, ALIGN_BITS'(8));
        send_request(OP_ALLOC, 32'd100, ALIGN_BITS'(4));
        send_request(OP_QUERY, '0, '0);

        // Random sessions, each started from an idle block
        while (counted_ops < ITEM_TARGET) begin
            settle();
            if ($urandom_range(1)) write_reg(REG_ARENA_BASE, pick_arena_base());
            if ($urandom_range(1)) write_reg(REG_GROW_ENABLE, 32'($urandom_range(1)));
            kind  = $urandom_range(99);
            burst = $urandom_range(80, 20);
            // fill the table first so full-table paths are reached
            if (kind >= 60 && kind < 85)
                repeat (17) send_request(OP_ADD_PAGE, $urandom_range(256, 8), '0);
            repeat (burst) begin
                if (kind >= 85) begin
                    send_request(3'($urandom), $urandom, ALIGN_BITS'($urandom));
                end else begin
                    r = $urandom_range(99);
                    if (r < 50)
                        send_request(OP_ALLOC, pick_alloc_size(), pick_alignment());
                    else if (r < 68)
                        send_request(OP_ADD_PAGE, pick_page_size(), ALIGN_BITS'($urandom));
                    else if (r < 80)
                        send_request(OP_QUERY, $urandom, ALIGN_BITS'($urandom));
                    else if (r < 87)
                        send_request(OP_GC, $urandom, ALIGN_BITS'($urandom));
                    else if (r < 93)
                        send_request(OP_FREE_ALL, $urandom, ALIGN_BITS'($urandom));
                    else
                        send_request(3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST)),
                                     $urandom, ALIGN_BITS'($urandom));
                end
            end
        end

        // Drain and give the verdict
        steady = 1'b0;
        i_in_valid <= 1'b0;
        while (results_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("paged_bump_allocator_top regression: pass");
        else
            $display("paged_bump_allocator_top regression: fail");
        $finish;
    end

endmodule
